/* hdl/bitmap_free_list_allocator_top_macros.svh */
// assertion helpers used by the checker file
`ifndef BITMAP_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define BFL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define BFL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/bfl_alloc_pkg.sv */
`timescale 1ns / 1ps

package bfl_alloc_pkg;

  localparam int MAX_ENTRIES = 4096;
  localparam int WORD_BITS   = 32;
  localparam int WORD_COUNT  = (MAX_ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W      = $clog2(WORD_COUNT);
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = IDX_W + 1;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    OP_RESET,
    OP_ALLOC,
    OP_FREE,
    OP_COUNT
  } opcode_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_SPACE = 2'd1,
    STATUS_RANGE    = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t          opcode;
    logic [IDX_W-1:0] first_index;
    logic [CNT_W-1:0] entry_count;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] result_index;
    logic [CNT_W-1:0] reserved_count;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALLOC_LOAD,
    ST_ALLOC_BIT,
    ST_FREE_LOAD,
    ST_FREE_BIT,
    ST_CNT_RD,
    ST_CNT_FIN,
    ST_DONE
  } state_t;

  // content of a word that has not been written since the last fill
  function automatic word_t fill_word(logic [ADDR_W-1:0] addr, logic [CNT_W-1:0] total);
    logic [CNT_W-BIT_W-1:0] full;
    logic [BIT_W-1:0]       rem;
    word_t                  w;
    full = total[CNT_W-1:BIT_W];
    rem  = total[BIT_W-1:0];
    if ((CNT_W-BIT_W)'(addr) < full) begin
      w = '1;
    end else if ((CNT_W-BIT_W)'(addr) == full) begin
      w = ~(word_t'('1) << rem);
    end else begin
      w = '0;
    end
    return w;
  endfunction

  function automatic logic [BIT_W-1:0] low_pos(word_t onehot);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (onehot[i]) begin
        pos = pos | BIT_W'(i);
      end
    end
    return pos;
  endfunction

  function automatic logic [BIT_W:0] popcount(word_t w);
    return (BIT_W+1)'($countones(w));
  endfunction

endpackage

/* hdl/bitmap_free_list_allocator_top.sv */
// Bitmap free-list allocator over 4096 entries kept as 128 words of 32 bits in a RAM; a set
// bit marks a free entry. One request is worked at a time and req_ready is low until its
// response has been handed to the output register, which may wait for rsp_ready while the
// next request is taken. The time per request, from one accept to the earliest next accept,
// is set by the RAM read latency and the one-bit-per-cycle take/release step: reset-all goes
// straight to the response, allocate reads each word it visits and then takes entries from it,
// free releases its indices and reloads each word it touches, and count reads one RAM
// word per cycle. Reset, a cfg write and the reset opcode refill the map at once through
// per-word valid flags, so no clearing pass is needed.
`timescale 1ns / 1ps

module bitmap_free_list_allocator_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [bfl_alloc_pkg::CNT_W-1:0] cfg_write_data,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  bfl_alloc_pkg::req_t           req,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output bfl_alloc_pkg::rsp_t           rsp
);

  localparam int ADDR_W = bfl_alloc_pkg::ADDR_W;
  localparam int CNT_W  = bfl_alloc_pkg::CNT_W;
  localparam int IDX_W  = bfl_alloc_pkg::IDX_W;
  localparam int BIT_W  = bfl_alloc_pkg::BIT_W;
  localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(bfl_alloc_pkg::WORD_COUNT - 1);
  localparam logic [CNT_W-1:0]  MAX_TOTAL = CNT_W'(bfl_alloc_pkg::MAX_ENTRIES);

  bfl_alloc_pkg::state_t state, state_next;

  logic [CNT_W-1:0]                    entry_total;
  logic [CNT_W-1:0]                    total_eff;
  logic [bfl_alloc_pkg::WORD_COUNT-1:0] word_valid;

  logic [ADDR_W-1:0]           word_idx;
  logic [ADDR_W-1:0]           rd_addr_q;
  bfl_alloc_pkg::word_t        word_data;
  logic [CNT_W-1:0]            remaining;
  logic [CNT_W-1:0]            cur_idx;
  logic [IDX_W-1:0]            first_taken;
  logic                        took_any;
  logic [CNT_W-1:0]            free_acc;
  bfl_alloc_pkg::status_t      status_r;
  logic [IDX_W-1:0]            result_r;
  logic [CNT_W-1:0]            reserved_r;

  logic                        ram_we;
  logic [ADDR_W-1:0]           ram_raddr;
  bfl_alloc_pkg::word_t        ram_wdata;
  bfl_alloc_pkg::word_t        ram_rdata;
  bfl_alloc_pkg::word_t        word_in;
  bfl_alloc_pkg::word_t        low_bit;
  bfl_alloc_pkg::word_t        free_bit;
  logic                        req_fire;
  logic                        free_range;
  logic                        free_cross;
  logic                        rsp_load;

  assign total_eff  = (entry_total > MAX_TOTAL) ? MAX_TOTAL : entry_total;
  assign req_ready  = (state == bfl_alloc_pkg::ST_IDLE);
  assign req_fire   = req_valid && req_ready;
  assign word_in    = word_valid[rd_addr_q] ? ram_rdata
                                            : bfl_alloc_pkg::fill_word(rd_addr_q, total_eff);
  assign low_bit    = word_data & (~word_data + 1'b1);
  assign free_bit   = bfl_alloc_pkg::word_t'(1) << cur_idx[BIT_W-1:0];
  assign free_range = (cur_idx >= total_eff);
  assign free_cross = (cur_idx[BIT_W-1:0] == '1);
  assign rsp_load   = (state == bfl_alloc_pkg::ST_DONE) && (!rsp_valid || rsp_ready);

  bfl_alloc_ram #(
    .WIDTH(bfl_alloc_pkg::WORD_BITS),
    .DEPTH(bfl_alloc_pkg::WORD_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(word_idx),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bfl_alloc_pkg::ST_IDLE: begin
        if (req_fire) begin
          unique case (req.opcode)
            bfl_alloc_pkg::OP_RESET: state_next = bfl_alloc_pkg::ST_DONE;
            bfl_alloc_pkg::OP_ALLOC: state_next = (req.entry_count == '0) ?
                                       bfl_alloc_pkg::ST_DONE : bfl_alloc_pkg::ST_ALLOC_LOAD;
            bfl_alloc_pkg::OP_FREE:  state_next = (req.entry_count == '0) ?
                                       bfl_alloc_pkg::ST_DONE : bfl_alloc_pkg::ST_FREE_LOAD;
            bfl_alloc_pkg::OP_COUNT: state_next = bfl_alloc_pkg::ST_CNT_RD;
            default:                 state_next = bfl_alloc_pkg::ST_DONE;
          endcase
        end
      end
      bfl_alloc_pkg::ST_ALLOC_LOAD: state_next = bfl_alloc_pkg::ST_ALLOC_BIT;
      bfl_alloc_pkg::ST_ALLOC_BIT: begin
        if (remaining == '0) begin
          state_next = bfl_alloc_pkg::ST_DONE;
        end else if (word_data == '0) begin
          state_next = (word_idx == LAST_WORD) ? bfl_alloc_pkg::ST_DONE
                                               : bfl_alloc_pkg::ST_ALLOC_LOAD;
        end
      end
      bfl_alloc_pkg::ST_FREE_LOAD: state_next = bfl_alloc_pkg::ST_FREE_BIT;
      bfl_alloc_pkg::ST_FREE_BIT: begin
        if (remaining == '0 || free_range) begin
          state_next = bfl_alloc_pkg::ST_DONE;
        end else if (free_cross) begin
          state_next = bfl_alloc_pkg::ST_FREE_LOAD;
        end
      end
      bfl_alloc_pkg::ST_CNT_RD: begin
        if (word_idx == LAST_WORD) begin
          state_next = bfl_alloc_pkg::ST_CNT_FIN;
        end
      end
      bfl_alloc_pkg::ST_CNT_FIN: state_next = bfl_alloc_pkg::ST_DONE;
      bfl_alloc_pkg::ST_DONE: begin
        if (rsp_load) begin
          state_next = bfl_alloc_pkg::ST_IDLE;
        end
      end
      default: state_next = bfl_alloc_pkg::ST_IDLE;
    endcase
  end

  // ram control
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = word_data;
    ram_raddr = word_idx;
    unique case (state)
      bfl_alloc_pkg::ST_IDLE: begin
        ram_raddr = (req.opcode == bfl_alloc_pkg::OP_FREE) ? req.first_index[IDX_W-1:BIT_W]
                                                            : '0;
      end
      bfl_alloc_pkg::ST_ALLOC_BIT: begin
        if (remaining == '0 || word_data == '0) begin
          ram_we    = 1'b1;
          ram_raddr = ADDR_W'(word_idx + 1'b1);
        end
      end
      bfl_alloc_pkg::ST_FREE_BIT: begin
        if (remaining == '0 || free_range) begin
          ram_we = 1'b1;
        end else if (free_cross) begin
          // word finished: write it back and fetch the next one
          ram_we    = 1'b1;
          ram_wdata = word_data | free_bit;
          ram_raddr = ADDR_W'(word_idx + 1'b1);
        end
      end
      bfl_alloc_pkg::ST_CNT_RD: ram_raddr = ADDR_W'(word_idx + 1'b1);
      default: ram_raddr = word_idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfl_alloc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_total <= MAX_TOTAL;
    end else if (cfg_write_en) begin
      entry_total <= cfg_write_data;
    end
  end

  // an invalid word reads as the fill pattern for the current total
  always_ff @(posedge clk) begin
    if (rst || cfg_write_en || (req_fire && req.opcode == bfl_alloc_pkg::OP_RESET)) begin
      word_valid <= '0;
    end else if (ram_we) begin
      word_valid[word_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_q <= ram_raddr;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      bfl_alloc_pkg::ST_IDLE: begin
        if (req_fire) begin
          word_idx    <= (req.opcode == bfl_alloc_pkg::OP_FREE) ?
                           req.first_index[IDX_W-1:BIT_W] : '0;
          remaining   <= req.entry_count;
          cur_idx     <= CNT_W'(req.first_index);
          took_any    <= 1'b0;
          first_taken <= '0;
          free_acc    <= '0;
          status_r    <= bfl_alloc_pkg::STATUS_OK;
          result_r    <= '0;
          reserved_r  <= '0;
        end
      end
      bfl_alloc_pkg::ST_ALLOC_LOAD: word_data <= word_in;
      bfl_alloc_pkg::ST_ALLOC_BIT: begin
        if (remaining == '0) begin
          result_r <= first_taken;
        end else if (word_data == '0) begin
          if (word_idx == LAST_WORD) begin
            status_r <= bfl_alloc_pkg::STATUS_NO_SPACE;
          end else begin
            word_idx <= ADDR_W'(word_idx + 1'b1);
          end
        end else begin
          word_data <= word_data & ~low_bit;
          remaining <= CNT_W'(remaining - 1'b1);
          took_any  <= 1'b1;
          if (!took_any) begin
            first_taken <= {word_idx, bfl_alloc_pkg::low_pos(low_bit)};
          end
        end
      end
      bfl_alloc_pkg::ST_FREE_LOAD: word_data <= word_in;
      bfl_alloc_pkg::ST_FREE_BIT: begin
        if (remaining == '0) begin
          status_r <= bfl_alloc_pkg::STATUS_OK;
        end else if (free_range) begin
          status_r <= bfl_alloc_pkg::STATUS_RANGE;
        end else begin
          word_data <= word_data | free_bit;
          cur_idx   <= CNT_W'(cur_idx + 1'b1);
          remaining <= CNT_W'(remaining - 1'b1);
          if (free_cross) begin
            word_idx <= ADDR_W'(word_idx + 1'b1);
          end
        end
      end
      bfl_alloc_pkg::ST_CNT_RD: begin
        free_acc <= CNT_W'(free_acc + CNT_W'(bfl_alloc_pkg::popcount(word_in)));
        word_idx <= ADDR_W'(word_idx + 1'b1);
      end
      bfl_alloc_pkg::ST_CNT_FIN: begin
        reserved_r <= (total_eff >= free_acc) ? CNT_W'(total_eff - free_acc) : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.status         <= status_r;
      rsp.result_index   <= result_r;
      rsp.reserved_count <= reserved_r;
    end
  end

endmodule

/* hdl/bfl_alloc_ram.sv */
`timescale 1ns / 1ps

module bfl_alloc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/bfl_alloc_checker.sv */
`timescale 1ns / 1ps
`include "bitmap_free_list_allocator_top_macros.svh"

module bfl_alloc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input bfl_alloc_pkg::rsp_t           rsp
);

  // one transaction in flight: ready drops right after an accept
  `BFL_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "accepted while busy")

  `BFL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp changed while stalled")

  // a failed request never reports an index or a count
  `BFL_ASSERT_NOW(a_fail_no_index, rsp_valid && rsp.status != bfl_alloc_pkg::STATUS_OK, rsp.result_index == '0 && rsp.reserved_count == '0, "failure carries data")

  // index and count come from different opcodes
  `BFL_ASSERT_NOW(a_index_or_count, rsp_valid && rsp.result_index != '0, rsp.reserved_count == '0, "index and count both set")

endmodule

bind bitmap_free_list_allocator_top bfl_alloc_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_ready(req_ready),
  .rsp_valid(rsp_valid),
  .rsp_ready(rsp_ready),
  .rsp      (rsp)
);
